// ===== rtl/gbfp_pkg.sv =====
// Shared types and constants of the binary frame parser.
`default_nettype none
package gbfp_pkg;

	localparam logic [7:0] SYNC_BYTE_A    = 8'hB5;
	localparam logic [7:0] SYNC_BYTE_B    = 8'h62;
	localparam logic [7:0] CLS_NAV        = 8'h01;
	localparam logic [7:0] ID_NAV_SOL     = 8'h06;
	localparam logic [7:0] ID_NAV_TIMEUTC = 8'h21;
	localparam logic [7:0] CLS_TIM        = 8'h0D;
	localparam logic [7:0] ID_TIM_TM2     = 8'h03;

	typedef enum logic [3:0] {
		PH_SYNC1 = 4'd0,
		PH_SYNC2 = 4'd1,
		PH_CLASS = 4'd2,
		PH_ID    = 4'd3,
		PH_LEN1  = 4'd4,
		PH_LEN2  = 4'd5,
		PH_DATA  = 4'd6,
		PH_CKA   = 4'd7,
		PH_CKB   = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NAV_SOL     = 2'd0,
		KIND_NAV_TIMEUTC = 2'd1,
		KIND_TIM_TM2     = 2'd2
	} kind_t;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  class_byte;
		kind_t       kind;
		logic [15:0] remaining;
		logic [7:0]  offset;
		logic [7:0]  sum_a;
		logic [7:0]  sum_b;
	} parse_state_t;

	typedef struct packed {
		logic [3:0] parser_state;
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic [7:0] payload_offset;
		logic [1:0] message_kind;
		logic       frame_done;
		logic       frame_good;
		logic       too_long;
	} parse_result_t;

endpackage
`default_nettype wire

// ===== rtl/gbfp_step.sv =====
// Next-state and result logic of the frame parser for one received byte.
`default_nettype none
module gbfp_step #(
	parameter int MAX_PAYLOAD = 256
) (
	input  gbfp_pkg::parse_state_t  cur,
	input  logic [7:0]              rx_byte,
	input  logic [2:0]              kind_enable,
	output gbfp_pkg::parse_state_t  nxt,
	output gbfp_pkg::parse_result_t res
);
	import gbfp_pkg::*;

	localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

	logic [7:0]  sum_a_add;
	logic [7:0]  sum_b_add;
	logic [15:0] len_full;
	logic [15:0] rem_dec;
	logic [3:0]  enable_ext;

	assign sum_a_add  = cur.sum_a + rx_byte;
	assign sum_b_add  = cur.sum_b + sum_a_add;
	assign len_full   = {rx_byte, cur.remaining[7:0]};
	assign rem_dec    = cur.remaining - 16'd1;
	assign enable_ext = {1'b0, kind_enable};

	always_comb begin
		nxt = cur;
		res = '0;
		unique case (cur.phase)
			PH_SYNC2: begin
				if (rx_byte == SYNC_BYTE_B) begin
					nxt.phase = PH_CLASS;
				end else if (rx_byte == SYNC_BYTE_A) begin
					nxt.phase = PH_SYNC2;
				end else begin
					nxt.phase = PH_SYNC1;
				end
			end
			PH_CLASS: begin
				nxt.class_byte = rx_byte;
				nxt.sum_a      = rx_byte;
				nxt.sum_b      = rx_byte;
				nxt.phase      = PH_ID;
			end
			PH_ID: begin
				nxt.sum_a = sum_a_add;
				nxt.sum_b = sum_b_add;
				if (cur.class_byte == CLS_NAV && rx_byte == ID_NAV_SOL) begin
					nxt.kind  = KIND_NAV_SOL;
					nxt.phase = PH_LEN1;
					res.message_kind = KIND_NAV_SOL;
				end else if (cur.class_byte == CLS_NAV && rx_byte == ID_NAV_TIMEUTC) begin
					nxt.kind  = KIND_NAV_TIMEUTC;
					nxt.phase = PH_LEN1;
					res.message_kind = KIND_NAV_TIMEUTC;
				end else if (cur.class_byte == CLS_TIM && rx_byte == ID_TIM_TM2) begin
					nxt.kind  = KIND_TIM_TM2;
					nxt.phase = PH_LEN1;
					res.message_kind = KIND_TIM_TM2;
				end else begin
					nxt.phase = PH_SYNC1;
				end
			end
			PH_LEN1: begin
				nxt.sum_a     = sum_a_add;
				nxt.sum_b     = sum_b_add;
				nxt.remaining = {8'd0, rx_byte};
				nxt.phase     = PH_LEN2;
				res.message_kind = cur.kind;
			end
			PH_LEN2: begin
				nxt.sum_a     = sum_a_add;
				nxt.sum_b     = sum_b_add;
				nxt.remaining = len_full;
				nxt.offset    = 8'd0;
				res.message_kind = cur.kind;
				if (len_full > MaxLen) begin
					res.too_long = 1'b1;
					nxt.phase    = PH_SYNC1;
				end else if (len_full == 16'd0) begin
					nxt.phase = PH_CKA;
				end else begin
					nxt.phase = PH_DATA;
				end
			end
			PH_DATA: begin
				nxt.sum_a          = sum_a_add;
				nxt.sum_b          = sum_b_add;
				res.payload_valid  = 1'b1;
				res.payload_byte   = rx_byte;
				res.payload_offset = cur.offset;
				res.message_kind   = cur.kind;
				nxt.offset         = cur.offset + 8'd1;
				nxt.remaining      = rem_dec;
				if (rem_dec == 16'd0) begin
					nxt.phase = PH_CKA;
				end
			end
			PH_CKA: begin
				res.message_kind = cur.kind;
				if (rx_byte == cur.sum_a) begin
					nxt.phase = PH_CKB;
				end else begin
					res.frame_done = 1'b1;
					nxt.phase      = PH_SYNC1;
				end
			end
			PH_CKB: begin
				res.message_kind = cur.kind;
				res.frame_done   = 1'b1;
				res.frame_good   = (rx_byte == cur.sum_b) && enable_ext[cur.kind];
				nxt.phase        = PH_SYNC1;
			end
			default: begin
				nxt.phase = (rx_byte == SYNC_BYTE_A) ? PH_SYNC2 : PH_SYNC1;
			end
		endcase
		res.parser_state = nxt.phase;
	end

endmodule
`default_nettype wire

// ===== rtl/gbfp_out_buf.sv =====
// Two-entry output buffer that holds results while the receiver stalls.
`default_nettype none
module gbfp_out_buf (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  gbfp_pkg::parse_result_t push_data,
	output logic                    space,
	output logic                    out_valid,
	input  logic                    out_ready,
	output gbfp_pkg::parse_result_t out_data
);
	import gbfp_pkg::*;

	logic          main_v_q;
	logic          skid_v_q;
	parse_result_t main_q;
	parse_result_t skid_q;
	logic          pop;

	assign pop       = main_v_q && out_ready;
	assign space     = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!main_v_q) begin
				main_v_q <= push;
			end else if (pop) begin
				if (skid_v_q) begin
					skid_v_q <= push;
				end else begin
					main_v_q <= push;
				end
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q) begin
			main_q <= push_data;
		end else if (pop) begin
			if (skid_v_q) begin
				main_q <= skid_q;
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/gnss_binary_frame_parser_core.sv =====
// Top level of the binary frame parser: input stage, parse state and output buffer.
// The block takes one received byte per input transaction (in_valid, in_ready, rx_byte)
// and returns exactly one result per byte on the output channel (out_valid, out_ready):
// the parser phase after the byte, the payload byte with its offset and message kind,
// and the frame_done, frame_good and too_long flags at the end of a frame.
// The enable mask for the three message kinds is written through the configuration
// channel (cfg_valid, cfg_ready, kind_enable); cfg_ready is always high and a write
// should only be made while no result is outstanding.
// A byte is captured in an input register, the parse step runs on it from there and
// its result lands in the output buffer, which drives out_valid and the result fields.
// One byte per cycle is sustained while the receiver keeps taking results; the parse
// step that updates the frame state is combinational.
// When the receiver stalls, a two-entry output buffer absorbs results and in_ready falls
// only once both entries and the input register are full; nothing is dropped.
// Reset returns the parser to waiting for the first sync byte, clears the checksums,
// empties all stages and sets the enable mask to all kinds enabled.
`default_nettype none
module gnss_binary_frame_parser_core #(
	parameter int MAX_PAYLOAD = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] kind_enable,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] parser_state,
	output logic       payload_valid,
	output logic [7:0] payload_byte,
	output logic [7:0] payload_offset,
	output logic [1:0] message_kind,
	output logic       frame_done,
	output logic       frame_good,
	output logic       too_long
);
	import gbfp_pkg::*;

	logic [2:0]    kind_enable_q;
	logic          valid_s1;
	logic [7:0]    rx_byte_s1;
	parse_state_t  state_q;
	parse_state_t  state_nxt;
	parse_result_t step_res;
	parse_result_t buf_data;
	logic          buf_space;
	logic          advance;
	logic          in_fire;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && buf_space;
	assign in_ready  = !valid_s1 || advance;
	assign in_fire   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_enable_q <= 3'd7;
		end else if (cfg_valid) begin
			kind_enable_q <= kind_enable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_SYNC1, class_byte: 8'd0, kind: KIND_NAV_SOL,
				remaining: 16'd0, offset: 8'd0, sum_a: 8'd0, sum_b: 8'd0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	gbfp_step #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_step (
		.cur        (state_q),
		.rx_byte    (rx_byte_s1),
		.kind_enable(kind_enable_q),
		.nxt        (state_nxt),
		.res        (step_res)
	);

	gbfp_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (advance),
		.push_data(step_res),
		.space    (buf_space),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (buf_data)
	);

	assign parser_state   = buf_data.parser_state;
	assign payload_valid  = buf_data.payload_valid;
	assign payload_byte   = buf_data.payload_byte;
	assign payload_offset = buf_data.payload_offset;
	assign message_kind   = buf_data.message_kind;
	assign frame_done     = buf_data.frame_done;
	assign frame_good     = buf_data.frame_good;
	assign too_long       = buf_data.too_long;

endmodule
`default_nettype wire
